FILE: hdl/rmp_pkg.sv
// Shared types, constants and layer functions for the reduced PRINCE-style cipher.
// Used by rmp_cipher and reduced_modified_prince_encrypt; depends on nothing.
`timescale 1ns / 1ps

package rmp_pkg;

   localparam int ROUNDS     = 3;
   localparam int BLOCK_W    = 64;
   localparam int NIB_COUNT  = 16;
   localparam int RC_COUNT   = 6;
   localparam int RC_IDX_W   = 3;
   localparam int CSR_IDX_W  = 1;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [3:0]         nibble_type;

   localparam logic [CSR_IDX_W-1:0] REG_WHITENING_KEY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_CORE_KEY      = 1'b1;

   localparam block_type ALPHA = 64'hc0ac29b7c97c50dd;

   localparam nibble_type SBOX_FWD [NIB_COUNT] = '{
      4'hb, 4'hf, 4'h3, 4'h2, 4'ha, 4'hc, 4'h9, 4'h1,
      4'h6, 4'h7, 4'h8, 4'h0, 4'he, 4'h5, 4'hd, 4'h4};
   localparam nibble_type SBOX_INV [NIB_COUNT] = '{
      4'hb, 4'h7, 4'h3, 4'h2, 4'hf, 4'hd, 4'h8, 4'h9,
      4'ha, 4'h6, 4'h4, 4'h0, 4'h5, 4'he, 4'hc, 4'h1};
   localparam nibble_type PERM_SR [NIB_COUNT] = '{
      4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
      4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11};
   localparam nibble_type PERM_ISR [NIB_COUNT] = '{
      4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
      4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3};

   function automatic block_type rc_at(input logic [RC_IDX_W-1:0] idx);
      block_type rc;
      case (idx)
         3'd0:    rc = 64'h0000000000000000;
         3'd1:    rc = 64'h13198a2e03707344;
         3'd2:    rc = 64'ha4093822299f31d0;
         3'd3:    rc = 64'h082efa98ec4e6c89;
         3'd4:    rc = 64'h452821e638d01377;
         3'd5:    rc = 64'hbe5466cf34e90c6c;
         default: rc = '0;
      endcase
      return rc;
   endfunction

   function automatic nibble_type get_nib(input block_type w, input int n);
      return w[BLOCK_W-4-4*n +: 4];
   endfunction

   function automatic block_type sub_fwd(input block_type w);
      block_type r;
      for (int n = 0; n < NIB_COUNT; n++) begin
         r[BLOCK_W-4-4*n +: 4] = SBOX_FWD[get_nib(w, n)];
      end
      return r;
   endfunction

   function automatic block_type sub_inv(input block_type w);
      block_type r;
      for (int n = 0; n < NIB_COUNT; n++) begin
         r[BLOCK_W-4-4*n +: 4] = SBOX_INV[get_nib(w, n)];
      end
      return r;
   endfunction

   function automatic block_type shift_rows(input block_type w);
      block_type r;
      for (int n = 0; n < NIB_COUNT; n++) begin
         r[BLOCK_W-4-4*n +: 4] = get_nib(w, int'(PERM_SR[n]));
      end
      return r;
   endfunction

   function automatic block_type inv_shift_rows(input block_type w);
      block_type r;
      for (int n = 0; n < NIB_COUNT; n++) begin
         r[BLOCK_W-4-4*n +: 4] = get_nib(w, int'(PERM_ISR[n]));
      end
      return r;
   endfunction

   // M' layer: outer columns use M0, inner columns M1 (rows rotated by one)
   function automatic block_type mix_layer(input block_type w);
      block_type  r;
      nibble_type x [4];
      nibble_type total;
      logic [1:0] row;
      logic [1:0] excl;
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            x[j] = get_nib(w, 4*c + j);
         end
         total = x[0] ^ x[1] ^ x[2] ^ x[3];
         for (int j = 0; j < 4; j++) begin
            row = 2'(j + ((c == 1 || c == 2) ? 1 : 0));
            for (int b = 0; b < 4; b++) begin
               excl = 2'(7 - int'(row) - b);
               r[BLOCK_W-4-4*(4*c + j) + b] = total[b] ^ x[excl][b];
            end
         end
      end
      return r;
   endfunction

endpackage

FILE: hdl/rmp_cipher.sv
// Combinational cipher datapath: whitening, forward rounds, middle layer,
// backward rounds and output key. Depends on rmp_pkg.
`timescale 1ns / 1ps

module rmp_cipher (
   input  rmp_pkg::block_type plain,
   input  rmp_pkg::block_type k0,
   input  rmp_pkg::block_type k1,
   output rmp_pkg::block_type cipher
);

   rmp_pkg::block_type kout;
   rmp_pkg::block_type s;

   assign kout = (k0 >> 1) ^ {k0[rmp_pkg::BLOCK_W-2:0], k0[rmp_pkg::BLOCK_W-1]};

   always_comb begin
      s = plain ^ k0 ^ k1;
      for (int i = 1; i < rmp_pkg::ROUNDS; i++) begin
         s = rmp_pkg::sub_fwd(s);
         s = rmp_pkg::shift_rows(s);
         s = rmp_pkg::mix_layer(s);
         s = s ^ k1 ^ rmp_pkg::rc_at(rmp_pkg::RC_IDX_W'(i));
      end
      s = rmp_pkg::sub_fwd(s);
      s = rmp_pkg::mix_layer(s);
      s = rmp_pkg::sub_inv(s);
      for (int i = rmp_pkg::ROUNDS; i < 2*rmp_pkg::ROUNDS - 1; i++) begin
         s = s ^ k1 ^ rmp_pkg::rc_at(rmp_pkg::RC_IDX_W'(2*rmp_pkg::ROUNDS - 1 - i))
               ^ rmp_pkg::ALPHA;
         s = rmp_pkg::mix_layer(s);
         s = rmp_pkg::inv_shift_rows(s);
         s = rmp_pkg::sub_inv(s);
      end
      s = rmp_pkg::sub_fwd(s);
      cipher = s ^ k1 ^ rmp_pkg::ALPHA ^ kout;
   end

endmodule

FILE: hdl/reduced_modified_prince_encrypt.sv
// Top level of the reduced PRINCE-style encryptor: key registers, request
// register, result register and handshakes. Depends on rmp_pkg and rmp_cipher.
`timescale 1ns / 1ps
//
// Usage:
//   csr_we/csr_index/csr_wdata write the keys: index 0 is the whitening key
//   k0, index 1 the core key k1. Write them only while no request is in flight.
//   req_valid/req_ready carry one 64-bit plaintext block per request;
//   rsp_valid/rsp_ready return the matching ciphertext, in order.
// Path: an accepted request is loaded into the request register, and the result
//   register then takes the output of one combinational pass of the whole cipher
//   once the output is free; rsp_valid comes from the result register.
// Throughput: one block per cycle while rsp_ready is high; the request and result
//   registers form a two-entry pipe, so a request is taken while a result waits.
// Stall: when rsp_ready is low the result holds; the request register keeps
//   one more block, after which req_ready drops until the result is taken.
// Reset: both pipe stages empty, both keys zero.
//

module reduced_modified_prince_encrypt (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [63:0]                           req_plaintext,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [63:0]                           rsp_ciphertext,
   input  logic                                  csr_we,
   input  logic [rmp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [63:0]                           csr_wdata
);

   rmp_pkg::block_type k0_ff, k0_in;
   rmp_pkg::block_type k1_ff, k1_in;
   logic               s1_valid_ff, s1_valid_in;
   rmp_pkg::block_type s1_text_ff, s1_text_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rmp_pkg::block_type rsp_text_ff, rsp_text_in;
   rmp_pkg::block_type cipher;
   logic               out_free;
   logic               s1_advance;

   // hold keys unless written
   always_comb begin
      k0_in = k0_ff;
      k1_in = k1_ff;
      if (csr_we) begin
         case (csr_index)
            rmp_pkg::REG_WHITENING_KEY: k0_in = csr_wdata;
            rmp_pkg::REG_CORE_KEY:      k1_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rmp_cipher u_cipher (
      .plain  (s1_text_ff),
      .k0     (k0_ff),
      .k1     (k1_ff),
      .cipher (cipher)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_text_in   = s1_text_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_text_in  = rsp_text_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         rsp_text_in  = cipher;
      end
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_text_in  = req_plaintext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k0_ff        <= '0;
         k1_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k0_ff        <= k0_in;
         k1_ff        <= k1_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_text_ff  <= s1_text_in;
      rsp_text_ff <= rsp_text_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ciphertext = rsp_text_ff;

   a_advance_fills_output : assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("request left the input register without reaching the output");

   a_stalled_request_held : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_text_ff)))
      else $error("stalled request lost or changed");

   a_ready_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request refused while the pipe had room");

   a_reset_empties_pipe : assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipe not empty after reset");

endmodule
